// ===== src/icl_pkg.sv =====
`default_nettype none

package icl_pkg;

    localparam int INDEX_BITS    = 16;
    localparam int FRACTION_BITS = 12;
    localparam int NODE_COUNT    = 8;

    localparam int FIELD_BITS = 16;
    localparam int COLOR_BITS = 8;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int QUOT_BITS  = FRACTION_BITS + NODE_BITS;
    localparam int PROD_BITS  = INDEX_BITS + NODE_BITS;
    localparam int ACC_BITS   = COLOR_BITS + FRACTION_BITS + 1;
    localparam int TABLE_SIZE = 8;
    localparam int TABLE_BITS = 3;

    localparam logic [FIELD_BITS-1:0] SIZE_RESET = FIELD_BITS'(256);

    typedef logic [COLOR_BITS-1:0] color_t;

    typedef struct packed {
        color_t red;
        color_t green;
        color_t blue;
    } rgb_t;

    typedef struct packed {
        logic                  oor;
        logic [INDEX_BITS-1:0] rem;
        logic [QUOT_BITS-1:0]  dq;
    } div_beat_t;

    localparam rgb_t NODE_RGB [TABLE_SIZE] = '{
        '{red: 8'd0,   green: 8'd0,   blue: 8'd255},
        '{red: 8'd105, green: 8'd145, blue: 8'd2},
        '{red: 8'd0,   green: 8'd255, blue: 8'd29},
        '{red: 8'd180, green: 8'd255, blue: 8'd0},
        '{red: 8'd255, green: 8'd215, blue: 8'd6},
        '{red: 8'd255, green: 8'd143, blue: 8'd1},
        '{red: 8'd255, green: 8'd69,  blue: 8'd0},
        '{red: 8'd255, green: 8'd0,   blue: 8'd0}
    };

    function automatic logic [INDEX_BITS-1:0] to_index(input logic [FIELD_BITS-1:0] v);
        logic [FIELD_BITS+INDEX_BITS-1:0] ext;
        ext = {{INDEX_BITS{1'b0}}, v};
        return ext[INDEX_BITS-1:0];
    endfunction

    function automatic color_t blend(
        input color_t                   c0,
        input color_t                   c1,
        input logic [FRACTION_BITS-1:0] f
    );
        logic [ACC_BITS-1:0] acc;
        acc = ACC_BITS'(c0) * (ACC_BITS'(1) << FRACTION_BITS) - ACC_BITS'(c0) * ACC_BITS'(f)
            + ACC_BITS'(c1) * ACC_BITS'(f) + (ACC_BITS'(1) << (FRACTION_BITS - 1));
        return acc[FRACTION_BITS+COLOR_BITS-1:FRACTION_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== src/interpolated_colormap_lookup.sv =====
`default_nettype none

// Colormap lookup: gives the red, green and blue of entry palette_index in a
// table of palette_size colors that blends linearly between eight fixed colors
// running from blue to red. An index at or above palette_size returns zero
// color with index_out_of_range set. One beat is accepted per cycle while
// in_stall is low; each beat passes through an input stage, one pipelined
// restoring divider stage per quotient bit of the position, and a blend
// stage that is also the output register. Stalls are absorbed stage by
// stage, so empty stages keep filling while the output waits. palette_size
// is written through the cfg channel, which is always ready; write it only
// while no beats are in flight.
module interpolated_colormap_lookup (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [icl_pkg::FIELD_BITS-1:0]    palette_size,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [icl_pkg::FIELD_BITS-1:0]    palette_index,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [icl_pkg::COLOR_BITS-1:0]         red,
    output logic [icl_pkg::COLOR_BITS-1:0]         green,
    output logic [icl_pkg::COLOR_BITS-1:0]         blue,
    output logic                                   index_out_of_range
);

    logic [icl_pkg::FIELD_BITS-1:0]   size_reg;
    logic                             front_ready;
    logic                             stage_valid [icl_pkg::QUOT_BITS+1];
    logic                             stage_ready [icl_pkg::QUOT_BITS+1];
    icl_pkg::div_beat_t               stage_beat  [icl_pkg::QUOT_BITS+1];
    icl_pkg::rgb_t                    rgb;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= icl_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= palette_size;
        end
    end

    icl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (front_ready),
        .palette_index (palette_index),
        .size          (size_reg),
        .out_valid     (stage_valid[0]),
        .out_ready     (stage_ready[0]),
        .out_beat      (stage_beat[0])
    );

    assign in_stall = !front_ready;

    for (genvar i = 0; i < icl_pkg::QUOT_BITS; i++)
    begin : g_div
        icl_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .size      (size_reg),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_beat   (stage_beat[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_beat  (stage_beat[i+1])
        );
    end

    icl_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[icl_pkg::QUOT_BITS]),
        .in_ready  (stage_ready[icl_pkg::QUOT_BITS]),
        .in_beat   (stage_beat[icl_pkg::QUOT_BITS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rgb   (rgb),
        .out_oor   (index_out_of_range)
    );

    assign red   = rgb.red;
    assign green = rgb.green;
    assign blue  = rgb.blue;

endmodule

`default_nettype wire

// ===== src/icl_front.sv =====
`default_nettype none

module icl_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [icl_pkg::FIELD_BITS-1:0]    palette_index,
    input  wire logic [icl_pkg::FIELD_BITS-1:0]    size,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output icl_pkg::div_beat_t                     out_beat
);

    logic                               valid_reg;
    icl_pkg::div_beat_t                 beat_reg;
    icl_pkg::div_beat_t                 beat_next;
    logic [icl_pkg::INDEX_BITS-1:0]     idx;
    logic [icl_pkg::INDEX_BITS-1:0]     sz;
    logic [icl_pkg::PROD_BITS-1:0]      prod;

    assign idx  = icl_pkg::to_index(palette_index);
    assign sz   = icl_pkg::to_index(size);
    assign prod = icl_pkg::PROD_BITS'(idx) * icl_pkg::PROD_BITS'(icl_pkg::NODE_COUNT - 1);

    // dividend is prod << FRACTION_BITS; top part starts as remainder
    always_comb
    begin
        beat_next.oor = (idx >= sz);
        beat_next.rem = prod[icl_pkg::PROD_BITS-1:icl_pkg::NODE_BITS];
        beat_next.dq  = {prod[icl_pkg::NODE_BITS-1:0], {icl_pkg::FRACTION_BITS{1'b0}}};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/icl_div_step.sv =====
`default_nettype none

module icl_div_step (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [icl_pkg::FIELD_BITS-1:0]    size,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire icl_pkg::div_beat_t                in_beat,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output icl_pkg::div_beat_t                     out_beat
);

    logic                               valid_reg;
    icl_pkg::div_beat_t                 beat_reg;
    icl_pkg::div_beat_t                 beat_next;
    logic [icl_pkg::INDEX_BITS:0]       trial;
    logic [icl_pkg::INDEX_BITS:0]       divisor;
    logic [icl_pkg::INDEX_BITS:0]       diff;
    logic                               take;

    // one restoring step: bring in next dividend bit, subtract if it fits
    assign trial   = {in_beat.rem, in_beat.dq[icl_pkg::QUOT_BITS-1]};
    assign divisor = {1'b0, icl_pkg::to_index(size)};
    assign diff    = trial - divisor;
    assign take    = (trial >= divisor);

    always_comb
    begin
        beat_next.oor = in_beat.oor;
        beat_next.rem = take ? diff[icl_pkg::INDEX_BITS-1:0] : trial[icl_pkg::INDEX_BITS-1:0];
        beat_next.dq  = {in_beat.dq[icl_pkg::QUOT_BITS-2:0], take};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/icl_blend.sv =====
`default_nettype none

module icl_blend (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire icl_pkg::div_beat_t    in_beat,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output icl_pkg::rgb_t              out_rgb,
    output logic                       out_oor
);

    logic                                  valid_reg;
    icl_pkg::rgb_t                         rgb_reg;
    icl_pkg::rgb_t                         rgb_next;
    logic                                  oor_reg;
    logic [icl_pkg::NODE_BITS-1:0]         node;
    logic [icl_pkg::NODE_BITS-1:0]         n0;
    logic [icl_pkg::NODE_BITS-1:0]         n1;
    logic [icl_pkg::FRACTION_BITS-1:0]     frac;
    icl_pkg::rgb_t                         c0;
    icl_pkg::rgb_t                         c1;

    assign node = in_beat.dq[icl_pkg::QUOT_BITS-1:icl_pkg::FRACTION_BITS];
    assign frac = in_beat.dq[icl_pkg::FRACTION_BITS-1:0];
    assign n0   = (node > icl_pkg::NODE_BITS'(icl_pkg::NODE_COUNT - 2))
                ? icl_pkg::NODE_BITS'(icl_pkg::NODE_COUNT - 2) : node;
    assign n1   = n0 + icl_pkg::NODE_BITS'(1);
    assign c0   = icl_pkg::NODE_RGB[icl_pkg::TABLE_BITS'(n0)];
    assign c1   = icl_pkg::NODE_RGB[icl_pkg::TABLE_BITS'(n1)];

    always_comb
    begin
        if (in_beat.oor)
        begin
            rgb_next = '0;
        end
        else
        begin
            rgb_next.red   = icl_pkg::blend(c0.red,   c1.red,   frac);
            rgb_next.green = icl_pkg::blend(c0.green, c1.green, frac);
            rgb_next.blue  = icl_pkg::blend(c0.blue,  c1.blue,  frac);
        end
    end

    assign in_ready  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_rgb   = rgb_reg;
    assign out_oor   = oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rgb_reg <= rgb_next;
            oor_reg <= in_beat.oor;
        end
    end

endmodule

`default_nettype wire

// ===== src/icl_checker.sv =====
`default_nettype none

module icl_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [icl_pkg::COLOR_BITS-1:0]    red,
    input  wire logic [icl_pkg::COLOR_BITS-1:0]    green,
    input  wire logic [icl_pkg::COLOR_BITS-1:0]    blue,
    input  wire logic                              index_out_of_range
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({red, green, blue, index_out_of_range}))
    else $error("result beat changed while stalled");

    // out of range beats carry no color
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_out_of_range |-> red == '0 && green == '0 && blue == '0)
    else $error("out of range beat with nonzero color");

    // input backpressure only comes from a full pipeline behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

    // nothing comes out right after reset
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result beat right after reset");

    // config channel never blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("config write not taken");

endmodule

bind interpolated_colormap_lookup icl_checker u_icl_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .red                (red),
    .green              (green),
    .blue               (blue),
    .index_out_of_range (index_out_of_range)
);

`default_nettype wire
